// ===== rtl/core/usb_standard_request_responder_assert.svh =====
// Assertion macros for the USB standard request responder.
`ifndef USB_STANDARD_REQUEST_RESPONDER_ASSERT_SVH
`define USB_STANDARD_REQUEST_RESPONDER_ASSERT_SVH
`ifndef SYNTH
`define USR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usr assertion failed");
`define USR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usr assertion failed");
`else
`define USR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define USR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/usr_pkg.sv =====
// Types, codes and descriptor tables shared by the request responder modules.
`timescale 1ns / 1ps
package usr_pkg;

    typedef enum logic [3:0] {
        ACT_GET_DESC   = 4'd0,
        ACT_SET_ADDR   = 4'd1,
        ACT_SET_CONFIG = 4'd2,
        ACT_GET_CONFIG = 4'd3,
        ACT_GET_IFACE  = 4'd4,
        ACT_SET_IFACE  = 4'd5,
        ACT_SET_FEAT   = 4'd6,
        ACT_CLR_FEAT   = 4'd7,
        ACT_GET_STATUS = 4'd8,
        ACT_BUS_RESET  = 4'd9,
        ACT_DISCONNECT = 4'd10
    } t_action;

    typedef enum logic [1:0] {
        RCP_DEVICE    = 2'd0,
        RCP_INTERFACE = 2'd1,
        RCP_ENDPOINT  = 2'd2,
        RCP_OTHER     = 2'd3
    } t_recipient;

    typedef enum logic [1:0] {
        ST_POWERED    = 2'd0,
        ST_DEFAULT    = 2'd1,
        ST_ADDRESS    = 2'd2,
        ST_CONFIGURED = 2'd3
    } t_link;

    typedef enum logic [3:0] {
        SRC_NONE    = 4'd0,
        SRC_DEVICE  = 4'd1,
        SRC_CONFIG  = 4'd2,
        SRC_LANGID  = 4'd3,
        SRC_MANUF   = 4'd4,
        SRC_PRODUCT = 4'd5,
        SRC_SERIAL  = 4'd6,
        SRC_CFGSTR  = 4'd7,
        SRC_IFSTR   = 4'd8,
        SRC_CFGVAL  = 4'd9,
        SRC_ALT     = 4'd10,
        SRC_STATUS  = 4'd11
    } t_source;

    localparam logic [7:0]  DT_DEVICE    = 8'd1;
    localparam logic [7:0]  DT_CONFIG    = 8'd2;
    localparam logic [7:0]  DT_STRING    = 8'd3;
    localparam logic [7:0]  DT_QUALIFIER = 8'd6;
    localparam logic [7:0]  NUM_STRINGS  = 8'd6;
    localparam logic [15:0] LEN_DEVICE   = 16'h0012;
    localparam logic [15:0] LEN_LANGID   = 16'h0004;
    localparam logic [15:0] LEN_STATUS   = 16'd2;
    localparam logic [15:0] LEN_BYTE     = 16'd1;
    localparam logic [15:0] CFG_LEN_RST  = 16'd9;
    localparam logic [15:0] STATUS_SELF  = 16'd1;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  recipient;
        logic [15:0] w_value;
        logic [15:0] w_index;
        logic        class_accepts;
    } t_item;

    typedef struct packed {
        t_link       link;
        logic [7:0]  cfg_val;
        logic [7:0]  alt;
    } t_ctx;

    typedef struct packed {
        logic        success;
        logic        to_host;
        logic [3:0]  data_source;
        logic [15:0] data_length;
        logic [15:0] reply_value;
        logic        address_write;
        logic [6:0]  new_address;
        logic        stall_write;
        logic [3:0]  stall_endpoint;
        logic        stall_in;
        logic        configure_pulse;
        logic [1:0]  device_state;
    } t_result;

    function automatic logic [3:0] str_source(input logic [2:0] idx);
        case (idx)
            3'd0:    str_source = SRC_LANGID;
            3'd1:    str_source = SRC_MANUF;
            3'd2:    str_source = SRC_PRODUCT;
            3'd3:    str_source = SRC_SERIAL;
            3'd4:    str_source = SRC_CFGSTR;
            3'd5:    str_source = SRC_IFSTR;
            default: str_source = SRC_NONE;
        endcase
    endfunction

    function automatic logic [15:0] str_length(input logic [2:0] idx);
        case (idx)
            3'd0:    str_length = 16'h0004;
            3'd1:    str_length = 16'h0012;
            3'd2:    str_length = 16'h0016;
            3'd3:    str_length = 16'h0016;
            3'd4:    str_length = 16'h0006;
            3'd5:    str_length = 16'h0008;
            default: str_length = 16'h0000;
        endcase
    endfunction

endpackage

// ===== rtl/core/usb_standard_request_responder.sv =====
// Top level of the USB standard request responder.
//
// Input channel: i_in_valid / o_in_stall with the decoded request fields
// (or a bus reset / disconnect event); a transfer happens when valid is high
// and stall is low. Output channel: o_out_valid / i_out_stall carries one
// result per request. Configuration: i_cfg_valid / o_cfg_ready writes the
// configuration descriptor set length; ready is always high. The user must
// make writes only while no request is in flight; the block itself does
// not enforce this. Path: input register, then decode and device context
// update into the result register.
// Throughput: one transfer per cycle while the receiver does not stall, set by the single decode stage.
// Reset: device state powered, configuration value and alternate setting 0,
// configuration length 9, both stages empty.
// When the receiver stalls, the result register holds and the input
// register, if it is empty, takes one more request before o_in_stall rises.
`timescale 1ns / 1ps
`include "usb_standard_request_responder_assert.svh"
module usb_standard_request_responder
    import usr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_action,
    input  logic [1:0]  i_recipient,
    input  logic [15:0] i_w_value,
    input  logic [15:0] i_w_index,
    input  logic        i_class_accepts,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_success,
    output logic        o_to_host,
    output logic [3:0]  o_data_source,
    output logic [15:0] o_data_length,
    output logic [15:0] o_reply_value,
    output logic        o_address_write,
    output logic [6:0]  o_new_address,
    output logic        o_stall_write,
    output logic [3:0]  o_stall_endpoint,
    output logic        o_stall_in,
    output logic        o_configure_pulse,
    output logic [1:0]  o_device_state,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    logic        out_open;
    logic        advance;
    logic        in_take;
    t_ctx        ctx;
    t_ctx        ctx_next;
    t_result     res;
    logic [15:0] cfg_len;

    assign out_open    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_open;
    assign o_in_stall  = r_in_valid && !out_open;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
            if (out_open) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{action: i_action, recipient: i_recipient, w_value: i_w_value,
                      w_index: i_w_index, class_accepts: i_class_accepts};
        end
        if (advance) begin
            r_out <= res;
        end
    end

    usr_decode u_decode (
        .i_item    (r_in),
        .i_ctx     (ctx),
        .i_cfg_len (cfg_len),
        .o_res     (res),
        .o_ctx     (ctx_next)
    );

    usr_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_ctx_next  (ctx_next),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_ctx       (ctx),
        .o_cfg_len   (cfg_len)
    );

    assign o_out_valid       = r_out_valid;
    assign o_success         = r_out.success;
    assign o_to_host         = r_out.to_host;
    assign o_data_source     = r_out.data_source;
    assign o_data_length     = r_out.data_length;
    assign o_reply_value     = r_out.reply_value;
    assign o_address_write   = r_out.address_write;
    assign o_new_address     = r_out.new_address;
    assign o_stall_write     = r_out.stall_write;
    assign o_stall_endpoint  = r_out.stall_endpoint;
    assign o_stall_in        = r_out.stall_in;
    assign o_configure_pulse = r_out.configure_pulse;
    assign o_device_state    = r_out.device_state;

    `USR_ASSERT_IMPLY(a_cfg_pulse_state, i_clk, i_rst_n, r_out_valid && r_out.configure_pulse, r_out.device_state == ST_CONFIGURED)
    `USR_ASSERT_IMPLY(a_pulses_exclusive, i_clk, i_rst_n, r_out_valid, $onehot0({r_out.address_write, r_out.stall_write, r_out.configure_pulse}))
    `USR_ASSERT_IMPLY(a_reject_quiet, i_clk, i_rst_n, r_out_valid && !r_out.success, r_out.data_source == SRC_NONE && !r_out.address_write && !r_out.stall_write && !r_out.configure_pulse)
    `USR_ASSERT_NEXT(a_in_stage_holds, i_clk, i_rst_n, r_in_valid && !out_open, r_in_valid && $stable(r_in))

endmodule

// ===== rtl/core/usr_decode.sv =====
// Request decode: result fields and next device context for one request.
`timescale 1ns / 1ps
module usr_decode
    import usr_pkg::*;
(
    input  t_item       i_item,
    input  t_ctx        i_ctx,
    input  logic [15:0] i_cfg_len,
    output t_result     o_res,
    output t_ctx        o_ctx
);

    logic       idx_blocked;
    logic [7:0] desc_type;
    logic [7:0] desc_idx;
    t_result    res;
    t_ctx       nxt;

    assign desc_type   = i_item.w_value[15:8];
    assign desc_idx    = i_item.w_value[7:0];
    assign idx_blocked = (i_ctx.link != ST_CONFIGURED) && (i_item.w_index != 16'd0);

    always_comb begin
        res = '0;
        nxt = i_ctx;
        case (i_item.action)
            ACT_GET_DESC: begin
                if (desc_type == DT_DEVICE) begin
                    res.success     = 1'b1;
                    res.to_host     = 1'b1;
                    res.data_source = SRC_DEVICE;
                    res.data_length = LEN_DEVICE;
                end else if (desc_type == DT_CONFIG) begin
                    res.success     = 1'b1;
                    res.to_host     = 1'b1;
                    res.data_source = SRC_CONFIG;
                    res.data_length = i_cfg_len;
                end else if (desc_type == DT_STRING && desc_idx < NUM_STRINGS) begin
                    res.success     = 1'b1;
                    res.to_host     = 1'b1;
                    res.data_source = str_source(desc_idx[2:0]);
                    res.data_length = str_length(desc_idx[2:0]);
                end else if (desc_type == DT_QUALIFIER) begin
                    res.success     = 1'b1;
                    res.to_host     = 1'b1;
                    res.data_source = SRC_LANGID;
                    res.data_length = LEN_LANGID;
                end
            end
            ACT_SET_ADDR: begin
                res.success       = 1'b1;
                res.address_write = 1'b1;
                res.new_address   = i_item.w_value[6:0];
                nxt.link          = (i_item.w_value == 16'd0) ? ST_DEFAULT : ST_ADDRESS;
            end
            ACT_SET_CONFIG: begin
                nxt.cfg_val = i_item.w_value[7:0];
                if (i_item.w_value[7:0] == 8'd0) begin
                    nxt.link    = ST_ADDRESS;
                    res.success = 1'b1;
                end else if (i_item.class_accepts) begin
                    nxt.link            = ST_CONFIGURED;
                    res.success         = 1'b1;
                    res.configure_pulse = 1'b1;
                end
            end
            ACT_GET_CONFIG: begin
                res.success     = 1'b1;
                res.to_host     = 1'b1;
                res.data_source = SRC_CFGVAL;
                res.data_length = LEN_BYTE;
                res.reply_value = {8'd0, i_ctx.cfg_val};
            end
            ACT_GET_IFACE: begin
                if (i_ctx.link == ST_CONFIGURED) begin
                    res.success     = 1'b1;
                    res.to_host     = 1'b1;
                    res.data_source = SRC_ALT;
                    res.data_length = LEN_BYTE;
                    res.reply_value = {8'd0, i_ctx.alt};
                end
            end
            ACT_SET_IFACE: begin
                if (i_item.class_accepts) begin
                    nxt.alt     = i_item.w_value[7:0];
                    res.success = 1'b1;
                end
            end
            ACT_SET_FEAT, ACT_CLR_FEAT: begin
                if (!idx_blocked && i_item.recipient == RCP_ENDPOINT
                        && i_item.w_value == 16'd0) begin
                    res.success = 1'b1;
                    if (i_item.action == ACT_SET_FEAT) begin
                        res.stall_write    = 1'b1;
                        res.stall_endpoint = i_item.w_index[3:0];
                        res.stall_in       = i_item.w_index[7];
                    end
                end
            end
            ACT_GET_STATUS: begin
                if (!idx_blocked && i_item.recipient != RCP_OTHER) begin
                    res.success     = 1'b1;
                    res.to_host     = 1'b1;
                    res.data_source = SRC_STATUS;
                    res.data_length = LEN_STATUS;
                    res.reply_value = (i_item.recipient == RCP_DEVICE) ? STATUS_SELF : 16'd0;
                end
            end
            ACT_BUS_RESET: begin
                nxt.link    = ST_DEFAULT;
                nxt.cfg_val = 8'd0;
                res.success = 1'b1;
            end
            ACT_DISCONNECT: begin
                nxt.link    = ST_POWERED;
                nxt.cfg_val = 8'd0;
                res.success = 1'b1;
            end
            default: begin
                res.success = 1'b0;
            end
        endcase
        res.device_state = nxt.link;
    end

    assign o_res = res;
    assign o_ctx = nxt;

endmodule

// ===== rtl/core/usr_state.sv =====
// Device context and configuration length registers.
`timescale 1ns / 1ps
module usr_state
    import usr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  t_ctx        i_ctx_next,
    input  logic        i_cfg_write,
    input  logic [15:0] i_cfg_data,
    output t_ctx        o_ctx,
    output logic [15:0] o_cfg_len
);

    t_ctx        r_ctx;
    logic [15:0] r_cfg_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx     <= '{link: ST_POWERED, cfg_val: 8'd0, alt: 8'd0};
            r_cfg_len <= CFG_LEN_RST;
        end else begin
            if (i_advance) begin
                r_ctx <= i_ctx_next;
            end
            if (i_cfg_write) begin
                r_cfg_len <= i_cfg_data;
            end
        end
    end

    assign o_ctx     = r_ctx;
    assign o_cfg_len = r_cfg_len;

endmodule

// ===== tb/usb_standard_request_responder_test.sv =====
// Testbench for the USB standard request responder: directed table, then random requests.
`timescale 1ns / 1ps
module usb_standard_request_responder_test;
    import usr_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          PHASE_ITEMS  = 275;
    localparam logic [3:0]  ACT_RESERVED = 4'd15;

    typedef struct {
        t_item   req;
        logic    typed;
        t_result resp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_action = '0;
    logic [1:0]  i_recipient = '0;
    logic [15:0] i_w_value = '0;
    logic [15:0] i_w_index = '0;
    logic        i_class_accepts = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_success;
    logic        o_to_host;
    logic [3:0]  o_data_source;
    logic [15:0] o_data_length;
    logic [15:0] o_reply_value;
    logic        o_address_write;
    logic [6:0]  o_new_address;
    logic        o_stall_write;
    logic [3:0]  o_stall_endpoint;
    logic        o_stall_in;
    logic        o_configure_pulse;
    logic [1:0]  o_device_state;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    t_link       dev_state = ST_POWERED;
    logic [7:0]  cur_cfg_value = '0;
    logic [7:0]  cur_iface = '0;
    logic [7:0]  cur_alt = '0;
    logic [15:0] total_len = CFG_LEN_RST;

    t_result     pending_results[$];
    t_row        plan[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;

    usb_standard_request_responder i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_recipient       (i_recipient),
        .i_w_value         (i_w_value),
        .i_w_index         (i_w_index),
        .i_class_accepts   (i_class_accepts),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_success         (o_success),
        .o_to_host         (o_to_host),
        .o_data_source     (o_data_source),
        .o_data_length     (o_data_length),
        .o_reply_value     (o_reply_value),
        .o_address_write   (o_address_write),
        .o_new_address     (o_new_address),
        .o_stall_write     (o_stall_write),
        .o_stall_endpoint  (o_stall_endpoint),
        .o_stall_in        (o_stall_in),
        .o_configure_pulse (o_configure_pulse),
        .o_device_state    (o_device_state),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_result predict_response(input t_item rq);
        t_result    r;
        logic [7:0] dtype;
        logic [7:0] didx;
        logic       blocked;
        r = '0;
        dtype = rq.w_value[15:8];
        didx = rq.w_value[7:0];
        blocked = (dev_state != ST_CONFIGURED) && (rq.w_index != 16'd0);
        case (rq.action)
            ACT_GET_DESC: begin
                r.to_host = 1'b1;
                r.success = 1'b1;
                if (dtype == DT_DEVICE) begin
                    r.data_source = SRC_DEVICE;
                    r.data_length = LEN_DEVICE;
                end else if (dtype == DT_CONFIG) begin
                    r.data_source = SRC_CONFIG;
                    r.data_length = total_len;
                end else if (dtype == DT_QUALIFIER) begin
                    r.data_source = SRC_LANGID;
                    r.data_length = LEN_LANGID;
                end else if (dtype == DT_STRING) begin
                    case (didx)
                        8'd0: begin
                            r.data_source = SRC_LANGID;
                            r.data_length = 16'h0004;
                        end
                        8'd1: begin
                            r.data_source = SRC_MANUF;
                            r.data_length = 16'h0012;
                        end
                        8'd2: begin
                            r.data_source = SRC_PRODUCT;
                            r.data_length = 16'h0016;
                        end
                        8'd3: begin
                            r.data_source = SRC_SERIAL;
                            r.data_length = 16'h0016;
                        end
                        8'd4: begin
                            r.data_source = SRC_CFGSTR;
                            r.data_length = 16'h0006;
                        end
                        8'd5: begin
                            r.data_source = SRC_IFSTR;
                            r.data_length = 16'h0008;
                        end
                        default: r = '0;
                    endcase
                end else begin
                    r = '0;
                end
            end
            ACT_SET_ADDR: begin
                r.success = 1'b1;
                r.address_write = 1'b1;
                r.new_address = rq.w_value[6:0];
                dev_state = (rq.w_value == 16'd0) ? ST_DEFAULT : ST_ADDRESS;
            end
            ACT_SET_CONFIG: begin
                cur_cfg_value = rq.w_value[7:0];
                if (cur_cfg_value == 8'd0) begin
                    dev_state = ST_ADDRESS;
                    r.success = 1'b1;
                end else if (rq.class_accepts) begin
                    dev_state = ST_CONFIGURED;
                    r.success = 1'b1;
                    r.configure_pulse = 1'b1;
                end
            end
            ACT_GET_CONFIG: begin
                r.success = 1'b1;
                r.to_host = 1'b1;
                r.data_source = SRC_CFGVAL;
                r.data_length = LEN_BYTE;
                r.reply_value = {8'd0, cur_cfg_value};
            end
            ACT_GET_IFACE: begin
                if (dev_state == ST_CONFIGURED) begin
                    r.success = 1'b1;
                    r.to_host = 1'b1;
                    r.data_source = SRC_ALT;
                    r.data_length = LEN_BYTE;
                    r.reply_value = {8'd0, cur_alt};
                end
            end
            ACT_SET_IFACE: begin
                if (rq.class_accepts) begin
                    cur_iface = rq.w_index[7:0];
                    cur_alt = rq.w_value[7:0];
                    r.success = 1'b1;
                end
            end
            ACT_SET_FEAT, ACT_CLR_FEAT: begin
                if (!blocked && rq.recipient == RCP_ENDPOINT && rq.w_value == 16'd0) begin
                    r.success = 1'b1;
                    if (rq.action == ACT_SET_FEAT) begin
                        r.stall_write = 1'b1;
                        r.stall_endpoint = rq.w_index[3:0];
                        r.stall_in = rq.w_index[7];
                    end
                end
            end
            ACT_GET_STATUS: begin
                if (!blocked && rq.recipient != RCP_OTHER) begin
                    r.success = 1'b1;
                    r.to_host = 1'b1;
                    r.data_source = SRC_STATUS;
                    r.data_length = LEN_STATUS;
                    r.reply_value = (rq.recipient == RCP_DEVICE) ? STATUS_SELF : 16'd0;
                end
            end
            ACT_BUS_RESET: begin
                dev_state = ST_DEFAULT;
                cur_cfg_value = 8'd0;
                r.success = 1'b1;
            end
            ACT_DISCONNECT: begin
                dev_state = ST_POWERED;
                cur_cfg_value = 8'd0;
                r.success = 1'b1;
            end
            default: r = '0;
        endcase
        r.device_state = dev_state;
        return r;
    endfunction

    function automatic t_result answer(input logic ok, input logic th, input t_source src,
                                       input logic [15:0] len, input t_link st);
        t_result r;
        r = '0;
        r.success = ok;
        r.to_host = th;
        r.data_source = src;
        r.data_length = len;
        r.device_state = st;
        return r;
    endfunction

    function automatic void add_row(input logic [3:0] act, input logic [1:0] rcp,
                                    input logic [15:0] val, input logic [15:0] idx,
                                    input logic acc, input logic typed, input t_result exp);
        t_row row;
        row.req.action = act;
        row.req.recipient = rcp;
        row.req.w_value = val;
        row.req.w_index = idx;
        row.req.class_accepts = acc;
        row.typed = typed;
        row.resp = exp;
        plan.push_back(row);
    endfunction

    function automatic t_item random_request();
        t_item rq;
        int    pick;
        pick = $urandom_range(0, 99);
        rq.recipient = 2'($urandom_range(0, 3));
        rq.w_value = 16'($urandom);
        rq.w_index = 16'($urandom);
        rq.class_accepts = ($urandom_range(0, 3) != 0);
        if (pick < 20) begin
            rq.action = ACT_GET_DESC;
            if ($urandom_range(0, 7) != 0) begin
                case ($urandom_range(0, 3))
                    0:       rq.w_value[15:8] = DT_DEVICE;
                    1:       rq.w_value[15:8] = DT_CONFIG;
                    2:       rq.w_value[15:8] = DT_STRING;
                    default: rq.w_value[15:8] = DT_QUALIFIER;
                endcase
                rq.w_value[7:0] = 8'($urandom_range(0, 7));
            end
        end else if (pick < 28) begin
            rq.action = ACT_SET_ADDR;
            if ($urandom_range(0, 4) == 0)
                rq.w_value = 16'd0;
        end else if (pick < 40) begin
            rq.action = ACT_SET_CONFIG;
            if ($urandom_range(0, 3) == 0)
                rq.w_value[7:0] = 8'd0;
        end else if (pick < 48) begin
            rq.action = ACT_GET_CONFIG;
        end else if (pick < 56) begin
            rq.action = ACT_GET_IFACE;
        end else if (pick < 64) begin
            rq.action = ACT_SET_IFACE;
        end else if (pick < 82) begin
            rq.action = (pick < 74) ? ACT_SET_FEAT : ACT_CLR_FEAT;
            if ($urandom_range(0, 3) != 0) begin
                rq.recipient = RCP_ENDPOINT;
                rq.w_value = 16'd0;
            end
            case ($urandom_range(0, 2))
                0:       rq.w_index = 16'd0;
                1:       rq.w_index = 16'($urandom_range(0, 255));
                default: ;
            endcase
        end else if (pick < 92) begin
            rq.action = ACT_GET_STATUS;
            if ($urandom_range(0, 1) == 0)
                rq.w_index = 16'd0;
        end else if (pick < 95) begin
            rq.action = ACT_BUS_RESET;
        end else if (pick < 97) begin
            rq.action = ACT_DISCONNECT;
        end else begin
            rq.action = 4'($urandom_range(11, 15));
        end
        return rq;
    endfunction

    task automatic send_request(input t_item rq, input logic typed, input t_result exp);
        int      gap;
        t_result pred;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= rq.action;
        i_recipient <= rq.recipient;
        i_w_value <= rq.w_value;
        i_w_index <= rq.w_index;
        i_class_accepts <= rq.class_accepts;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pred = predict_response(rq);
        pending_results.push_back(typed ? exp : pred);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_total_length(input logic [15:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        total_len = len;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("success", 16'(want.success), 16'(o_success));
                check_field("to_host", 16'(want.to_host), 16'(o_to_host));
                check_field("data_source", 16'(want.data_source), 16'(o_data_source));
                check_field("data_length", want.data_length, o_data_length);
                check_field("reply_value", want.reply_value, o_reply_value);
                check_field("address_write", 16'(want.address_write), 16'(o_address_write));
                check_field("new_address", 16'(want.new_address), 16'(o_new_address));
                check_field("stall_write", 16'(want.stall_write), 16'(o_stall_write));
                check_field("stall_endpoint", 16'(want.stall_endpoint),
                            16'(o_stall_endpoint));
                check_field("stall_in", 16'(want.stall_in), 16'(o_stall_in));
                check_field("configure_pulse", 16'(want.configure_pulse),
                            16'(o_configure_pulse));
                check_field("device_state", 16'(want.device_state), 16'(o_device_state));
            end
        end
    end

    initial begin : result_receiver
        int n;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 17);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    initial begin : request_sender
        logic [15:0] phase_len[4];
        phase_len[0] = 16'hffff;
        phase_len[1] = 16'($urandom_range(9, 65535));
        phase_len[2] = CFG_LEN_RST;
        phase_len[3] = 16'($urandom_range(9, 65535));

        add_row(ACT_GET_DESC, RCP_DEVICE, 16'h0100, 16'h0000, 1'b0, 1'b1,
                answer(1'b1, 1'b1, SRC_DEVICE, LEN_DEVICE, ST_POWERED));
        add_row(ACT_GET_DESC, RCP_DEVICE, 16'h0200, 16'h0000, 1'b0, 1'b1,
                answer(1'b1, 1'b1, SRC_CONFIG, CFG_LEN_RST, ST_POWERED));
        for (int s = 0; s < 6; s++)
            add_row(ACT_GET_DESC, RCP_DEVICE, {DT_STRING, 8'(s)}, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_GET_DESC, RCP_DEVICE, 16'h0306, 16'h0000, 1'b1, 1'b1,
                answer(1'b0, 1'b0, SRC_NONE, 16'd0, ST_POWERED));
        add_row(ACT_GET_DESC, RCP_DEVICE, 16'h0600, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_GET_DESC, RCP_OTHER, 16'hffff, 16'hffff, 1'b1, 1'b1,
                answer(1'b0, 1'b0, SRC_NONE, 16'd0, ST_POWERED));
        add_row(ACT_GET_STATUS, RCP_DEVICE, 16'h0000, 16'hffff, 1'b0, 1'b1,
                answer(1'b0, 1'b0, SRC_NONE, 16'd0, ST_POWERED));
        add_row(ACT_BUS_RESET, RCP_DEVICE, 16'h0000, 16'h0000, 1'b0, 1'b1,
                answer(1'b1, 1'b0, SRC_NONE, 16'd0, ST_DEFAULT));
        add_row(ACT_SET_ADDR, RCP_DEVICE, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_SET_ADDR, RCP_DEVICE, 16'hffff, 16'hffff, 1'b1, 1'b0, '0);
        add_row(ACT_SET_CONFIG, RCP_DEVICE, 16'h0001, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_GET_CONFIG, RCP_DEVICE, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_GET_IFACE, RCP_INTERFACE, 16'h0000, 16'h0000, 1'b1, 1'b1,
                answer(1'b0, 1'b0, SRC_NONE, 16'd0, ST_ADDRESS));
        add_row(ACT_SET_CONFIG, RCP_DEVICE, 16'hffff, 16'hffff, 1'b1, 1'b0, '0);
        add_row(ACT_GET_CONFIG, RCP_DEVICE, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_SET_IFACE, RCP_INTERFACE, 16'hffff, 16'hffff, 1'b1, 1'b0, '0);
        add_row(ACT_GET_IFACE, RCP_INTERFACE, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_SET_FEAT, RCP_ENDPOINT, 16'h0000, 16'h008f, 1'b0, 1'b0, '0);
        add_row(ACT_CLR_FEAT, RCP_ENDPOINT, 16'h0000, 16'hffff, 1'b0, 1'b0, '0);
        add_row(ACT_SET_FEAT, RCP_DEVICE, 16'h0001, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_GET_STATUS, RCP_OTHER, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_GET_STATUS, RCP_ENDPOINT, 16'hffff, 16'hffff, 1'b0, 1'b0, '0);
        add_row(ACT_SET_IFACE, RCP_INTERFACE, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
        add_row(ACT_RESERVED, RCP_OTHER, 16'hffff, 16'hffff, 1'b1, 1'b1,
                answer(1'b0, 1'b0, SRC_NONE, 16'd0, ST_CONFIGURED));
        add_row(ACT_DISCONNECT, RCP_DEVICE, 16'h0000, 16'h0000, 1'b0, 1'b1,
                answer(1'b1, 1'b0, SRC_NONE, 16'd0, ST_POWERED));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_total_length(CFG_LEN_RST);
        foreach (plan[r])
            send_request(plan[r].req, plan[r].typed, plan[r].resp);

        for (int p = 0; p < 4; p++) begin
            drain();
            write_total_length(phase_len[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                quiet = (p == 1 && k < 60);
                if (p == 0 && k == 100)
                    hold_request = 1'b1;
                if (p == 2 && k == 137)
                    drain();
                send_request(random_request(), 1'b0, '0);
            end
            quiet = 1'b0;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
